/* rtl/sirt_pkg.sv */
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants for the signed integer to radix text block.
// ----------------------------------------------------------------------------
package sirt_pkg;

	localparam int WIDTH_DEF     = 32;
	localparam int MAX_RADIX_DEF = 16;
	localparam int NUM_SYMS      = 16;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 64;

	localparam logic [7:0] MINUS_SYM = 8'h2D;
	localparam logic [7:0] PLUS_SYM  = 8'h2B;

	// register index, taken from paddr[4:3]
	localparam logic [1:0] REG_ALPHA_LO = 2'd0;
	localparam logic [1:0] REG_ALPHA_HI = 2'd1;
	localparam logic [1:0] REG_RADIX    = 2'd2;

	typedef logic [7:0] sym_t;

	typedef struct packed {
		sym_t [NUM_SYMS-1:0] alpha;
		logic [4:0]          radix;
		logic                ok;
	} cfg_t;

endpackage

/* rtl/sirt_num_if.sv */
// ----------------------------------------------------------------------------
// sirt_num_if
// Input stream: one signed number per beat.
// ----------------------------------------------------------------------------
interface sirt_num_if #(
	parameter int W = sirt_pkg::WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] number;

	modport source(output valid, output number, input ready);
	modport sink(input valid, input number, output ready);
endinterface

/* rtl/sirt_char_if.sv */
// ----------------------------------------------------------------------------
// sirt_char_if
// Output stream: one text character per beat, last marks end of a number.
// ----------------------------------------------------------------------------
interface sirt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source(output valid, output character, output last, input ready);
	modport sink(input valid, input character, input last, output ready);
endinterface

/* rtl/sirt_cfg.sv */
// ----------------------------------------------------------------------------
// sirt_cfg
// APB register file for the alphabet and radix, plus the alphabet check.
// ----------------------------------------------------------------------------
module sirt_cfg #(
	parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sirt_pkg::ADDR_W-1:0] paddr,
	input  logic [sirt_pkg::DATA_W-1:0] pwdata,
	output logic [sirt_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output sirt_pkg::cfg_t              cfg
);
	import sirt_pkg::*;

	logic [DATA_W-1:0] alpha_lo_q;
	logic [DATA_W-1:0] alpha_hi_q;
	logic [4:0]        radix_q;
	logic [1:0]        idx;
	logic              wr;
	logic              bad;

	assign pready = 1'b1;
	assign idx    = paddr[4:3];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_lo_q <= '0;
			alpha_hi_q <= '0;
			radix_q    <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_ALPHA_LO: alpha_lo_q <= pwdata;
				REG_ALPHA_HI: alpha_hi_q <= pwdata;
				REG_RADIX:    radix_q    <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ALPHA_LO: prdata = alpha_lo_q;
			REG_ALPHA_HI: prdata = alpha_hi_q;
			REG_RADIX:    prdata = DATA_W'(radix_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.alpha = {alpha_hi_q, alpha_lo_q};
	assign cfg.radix = radix_q;

	// every used symbol: no sign characters, no two alike
	always_comb begin
		bad = 1'b0;
		for (int a = 0; a < NUM_SYMS; a++) begin
			if (5'(a) < radix_q) begin
				if (cfg.alpha[a] == MINUS_SYM || cfg.alpha[a] == PLUS_SYM)
					bad = 1'b1;
				for (int b = a + 1; b < NUM_SYMS; b++) begin
					if (5'(b) < radix_q && cfg.alpha[b] == cfg.alpha[a])
						bad = 1'b1;
				end
			end
		end
	end

	assign cfg.ok = !bad && radix_q >= 5'd2 && radix_q <= 5'(MAX_RADIX);

endmodule

/* rtl/sirt_fifo.sv */
// ----------------------------------------------------------------------------
// sirt_fifo
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module sirt_fifo #(
	parameter int DW = sirt_pkg::WIDTH_DEF + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);
	logic [DW-1:0] mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* rtl/sirt_front.sv */
// ----------------------------------------------------------------------------
// sirt_front
// Takes numbers in, drops them when the alphabet is bad, else queues
// sign and magnitude.
// ----------------------------------------------------------------------------
module sirt_front #(
	parameter int WIDTH = sirt_pkg::WIDTH_DEF
) (
	sirt_num_if.sink          req,
	input  sirt_pkg::cfg_t    cfg,
	input  logic              full,
	output logic              push,
	output logic [WIDTH:0]    wdata
);
	import sirt_pkg::*;

	logic             neg;
	logic [WIDTH-1:0] mag;

	assign req.ready = !full;
	assign neg       = req.number[WIDTH-1];
	// most negative value wraps to 2^(WIDTH-1), which is the right magnitude
	assign mag       = neg ? WIDTH'(-req.number) : WIDTH'(req.number);
	assign push      = req.valid && !full && cfg.ok;
	assign wdata     = {neg, mag};

endmodule

/* rtl/sirt_back.sv */
// ----------------------------------------------------------------------------
// sirt_back
// Digit engine: repeated division by the radix, 8 quotient bits per cycle,
// digits stacked LSB first, then sent MSB first after an optional sign.
// ----------------------------------------------------------------------------
module sirt_back #(
	parameter int WIDTH = sirt_pkg::WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sirt_pkg::cfg_t cfg,
	input  logic           empty,
	input  logic [WIDTH:0] rdata,
	output logic           pop,
	sirt_char_if.source    txt
);
	import sirt_pkg::*;

	localparam int NCH = (WIDTH + 7) / 8;
	localparam int PW  = NCH * 8;
	localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CW  = $clog2(WIDTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_NXT, S_EMIT} state_t;

	state_t         state_q;
	logic [PW-1:0]  quo_q;
	logic [3:0]     rem_q;
	logic [CIW-1:0] ci_q;
	logic           sign_pend_q;
	logic [3:0]     stk_q [WIDTH];
	logic [CW-1:0]  cnt_q;
	logic           ovalid_q;
	logic [7:0]     char_q;
	logic           last_q;

	logic [7:0]     chunk;
	logic [7:0]     qbits;
	logic [4:0]     t;
	logic [3:0]     r;
	logic [PW-1:0]  quo_nx;
	logic [PW-1:0]  mag_in;

	function automatic logic [CIW-1:0] top_chunk(input logic [PW-1:0] v);
		logic [CIW-1:0] idx;
		idx = '0;
		for (int k = 0; k < NCH; k++) begin
			if (v[k*8 +: 8] != 8'd0)
				idx = CIW'(k);
		end
		return idx;
	endfunction

	assign mag_in = PW'(rdata[WIDTH-1:0]);
	assign pop    = (state_q == S_IDLE) && !empty;

	// one byte of restoring division per cycle; remainder always below radix
	always_comb begin
		chunk = '0;
		for (int k = 0; k < NCH; k++) begin
			if (ci_q == CIW'(k))
				chunk = quo_q[k*8 +: 8];
		end
		qbits = '0;
		r     = rem_q;
		t     = '0;
		for (int b = 7; b >= 0; b--) begin
			t = {r, chunk[b]};
			if (t >= cfg.radix) begin
				qbits[b] = 1'b1;
				t        = t - cfg.radix;
			end
			r = t[3:0];
		end
		quo_nx = quo_q;
		for (int k = 0; k < NCH; k++) begin
			if (ci_q == CIW'(k))
				quo_nx[k*8 +: 8] = qbits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ovalid_q    <= 1'b0;
			cnt_q       <= '0;
			sign_pend_q <= 1'b0;
		end else begin
			if (ovalid_q && txt.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						quo_q       <= mag_in;
						ci_q        <= top_chunk(mag_in);
						rem_q       <= '0;
						sign_pend_q <= rdata[WIDTH];
						cnt_q       <= '0;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q <= quo_nx;
					rem_q <= r;
					if (ci_q == '0) begin
						stk_q[0] <= r;
						for (int i = 1; i < WIDTH; i++)
							stk_q[i] <= stk_q[i-1];
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_NXT;
					end else begin
						ci_q <= ci_q - CIW'(1);
					end
				end
				S_NXT: begin
					if (quo_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						ci_q    <= top_chunk(quo_q);
						rem_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_EMIT: begin
					if (!ovalid_q || txt.ready) begin
						ovalid_q <= 1'b1;
						if (sign_pend_q) begin
							char_q      <= MINUS_SYM;
							last_q      <= 1'b0;
							sign_pend_q <= 1'b0;
						end else begin
							char_q <= cfg.alpha[stk_q[0]];
							last_q <= cnt_q == CW'(1);
							for (int i = 0; i < WIDTH - 1; i++)
								stk_q[i] <= stk_q[i+1];
							cnt_q <= cnt_q - CW'(1);
							if (cnt_q == CW'(1))
								state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign txt.valid     = ovalid_q;
	assign txt.character = char_q;
	assign txt.last      = last_q;

endmodule

/* rtl/signed_integer_to_radix_text_top.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top
// Signed integer to text in a configurable radix and alphabet.
//
//   channel  dir  beat
//   req      in   number (WIDTH bits, signed)
//   txt      out  character (8 bits), last
//   apb      in   64-bit register writes/reads: alphabet_low, alphabet_high, radix
//
// A number is popped from the queue while the engine is idle. Per digit, the
// division loop takes one byte of the running quotient per cycle, from its
// top nonzero byte down, then checks the quotient for zero; then characters
// go out one per cycle while txt is ready. A two-entry queue lets new numbers
// in while the engine works; txt stalls hold only the engine. Reset clears the
// control and config registers to zero; data registers get no reset or clearing.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top #(
	parameter int WIDTH     = sirt_pkg::WIDTH_DEF,
	parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sirt_pkg::ADDR_W-1:0] paddr,
	input  logic [sirt_pkg::DATA_W-1:0] pwdata,
	output logic [sirt_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	sirt_num_if.sink                    req,
	sirt_char_if.source                 txt
);
	import sirt_pkg::*;

	cfg_t           cfg_s;
	logic           push;
	logic           full;
	logic           pop;
	logic           empty;
	logic [WIDTH:0] wdata;
	logic [WIDTH:0] rdata;

	sirt_cfg #(.MAX_RADIX(MAX_RADIX)) u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg_s)
	);

	sirt_front #(.WIDTH(WIDTH)) u_front (
		.req(req), .cfg(cfg_s), .full(full), .push(push), .wdata(wdata)
	);

	sirt_fifo #(.DW(WIDTH + 1)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wdata), .full(full),
		.pop(pop), .rdata(rdata), .empty(empty)
	);

	sirt_back #(.WIDTH(WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_s), .empty(empty), .rdata(rdata),
		.pop(pop), .txt(txt)
	);

`ifndef SYNTHESIS
	// a sign is always followed by digits
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		txt.valid && txt.character == MINUS_SYM |-> !txt.last)
		else $error("minus sign marked last");

	// characters of one number go out with no gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		txt.valid && txt.ready && !txt.last |=> txt.valid)
		else $error("gap inside a number's text");

	a_ok_radix: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_s.ok |-> cfg_s.radix >= 5'd2 && cfg_s.radix <= 5'(MAX_RADIX))
		else $error("alphabet accepted with bad radix");
`endif

endmodule

/* tb/sirt_text_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_text_checker
// Watches the register port and both streams of the radix text block. It
// tracks the alphabet and radix from register writes, predicts the text of
// every accepted number and compares each text beat in order.
// ----------------------------------------------------------------------------
module sirt_text_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [sirt_pkg::ADDR_W-1:0]   paddr,
	input  logic [sirt_pkg::DATA_W-1:0]   pwdata,
	sirt_num_if                           num_mon,
	sirt_char_if                          text_mon,
	output int                            fails,
	output int                            due_count,
	output int                            chars_checked,
	output int                            silent_numbers
);
	import sirt_pkg::*;

	typedef struct packed {
		sym_t character;
		logic last;
	} text_beat_t;

	logic [63:0] alpha_lo_q;
	logic [63:0] alpha_hi_q;
	logic [4:0]  radix_q;
	text_beat_t  text_due[$];

	function automatic sym_t symbol(int k);
		logic [63:0] word;
		word = (k < 8) ? alpha_lo_q : alpha_hi_q;
		return word[(k % 8) * 8 +: 8];
	endfunction

	function automatic bit alphabet_usable();
		int n;
		n = radix_q;
		if (n < 2 || n > MAX_RADIX_DEF) begin
			return 1'b0;
		end
		for (int a = 0; a < n; a++) begin
			if (symbol(a) == MINUS_SYM || symbol(a) == PLUS_SYM) begin
				return 1'b0;
			end
			for (int b = a + 1; b < n; b++) begin
				if (symbol(b) == symbol(a)) begin
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	task automatic queue_text(input logic [WIDTH_DEF-1:0] value);
		logic [WIDTH_DEF-1:0] mag;
		logic [WIDTH_DEF-1:0] base;
		sym_t                 digits[$];
		text_beat_t           beat;
		if (!alphabet_usable()) begin
			silent_numbers++;
			return;
		end
		base = WIDTH_DEF'(radix_q);
		// two's complement negate also gives the right magnitude for the most negative value
		mag = value[WIDTH_DEF-1] ? -value : value;
		if (value[WIDTH_DEF-1]) begin
			beat.character = MINUS_SYM;
			beat.last = 1'b0;
			text_due.push_back(beat);
		end
		do begin
			digits.push_front(symbol(int'(mag % base)));
			mag = mag / base;
		end while (mag != 0);
		for (int i = 0; i < digits.size(); i++) begin
			beat.character = digits[i];
			beat.last = (i == digits.size() - 1);
			text_due.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_beat_t want;
		if (!arst_n) begin
			alpha_lo_q = '0;
			alpha_hi_q = '0;
			radix_q = '0;
			text_due.delete();
			fails = 0;
			due_count = 0;
			chars_checked = 0;
			silent_numbers = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:3])
					REG_ALPHA_LO: alpha_lo_q = pwdata;
					REG_ALPHA_HI: alpha_hi_q = pwdata;
					REG_RADIX:    radix_q = pwdata[4:0];
					default: ;
				endcase
			end
			// text beats first: a number accepted at this edge cannot have text out yet
			if (text_mon.valid && text_mon.ready) begin
				chars_checked++;
				if (text_due.size() == 0) begin
					if (fails < 10) begin
						$display("%0t: unexpected text beat: char %h last %b", $realtime,
							text_mon.character, text_mon.last);
					end
					fails++;
				end else begin
					want = text_due.pop_front();
					if (text_mon.character !== want.character || text_mon.last !== want.last) begin
						if (fails < 10) begin
							$display("%0t: text mismatch: expected char %h last %b, got char %h last %b",
								$realtime, want.character, want.last,
								text_mon.character, text_mon.last);
						end
						fails++;
					end
				end
			end
			if (num_mon.valid && num_mon.ready) begin
				queue_text(num_mon.number);
			end
			due_count = text_due.size();
		end
	end

endmodule

/* tb/signed_integer_to_radix_text_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_top_test
// Drives numbers and register writes into the radix text block under random
// idling on both streams; the checker predicts and compares the text.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text_top_test;
	import sirt_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 400;
	localparam int PHASE_ITEMS = 137;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	int fails;
	int due_count;
	int chars_checked;
	int silent_numbers;

	int src_idle;
	int recv_idle;
	int cur_radix;
	int numbers_sent;
	int reg_writes;
	int stall_cycles;

	sirt_num_if  num_bus ();
	sirt_char_if text_bus ();

	signed_integer_to_radix_text_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (num_bus),
		.txt     (text_bus)
	);

	sirt_text_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.num_mon        (num_bus),
		.text_mon       (text_bus),
		.fails          (fails),
		.due_count      (due_count),
		.chars_checked  (chars_checked),
		.silent_numbers (silent_numbers)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		text_bus.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((num_bus.valid && num_bus.ready) || (text_bus.valid && text_bus.ready)
				|| (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d text beats still due",
				stall_cycles, due_count);
			$display("** signed_integer_to_radix_text_top: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		reg_writes++;
	endtask

	task automatic wait_text_done();
		while (due_count != 0) @(negedge clk);
	endtask

	// registers only change with the block idle; invalid-alphabet numbers leave
	// no text behind, so give the engine time to swallow them
	task automatic configure(input logic [63:0] lo, input logic [63:0] hi, input int r);
		wait_text_done();
		repeat (DRAIN_WAIT) @(negedge clk);
		apb_write(REG_ALPHA_LO, lo);
		apb_write(REG_ALPHA_HI, hi);
		apb_write(REG_RADIX, DATA_W'(r));
		cur_radix = r;
	endtask

	task automatic send_number(input logic [WIDTH_DEF-1:0] value);
		while ($urandom_range(99) < src_idle) begin
			num_bus.valid = 1'b0;
			@(negedge clk);
		end
		num_bus.valid = 1'b1;
		num_bus.number = value;
		@(posedge clk);
		while (!num_bus.ready) @(posedge clk);
		@(negedge clk);
		num_bus.valid = 1'b0;
		numbers_sent++;
	endtask

	task automatic random_alphabet();
		sym_t        syms[16];
		bit          clash;
		int          r;
		int          a;
		int          b;
		int          pick;
		logic [63:0] lo;
		logic [63:0] hi;
		for (int k = 0; k < 16; k++) begin
			do begin
				syms[k] = sym_t'($urandom);
				clash = (syms[k] == MINUS_SYM || syms[k] == PLUS_SYM);
				for (int j = 0; j < k; j++) clash |= (syms[j] == syms[k]);
			end while (clash);
		end
		case ($urandom_range(9))
			0: r = 2;
			1: r = 16;
			default: r = $urandom_range(16, 2);
		endcase
		pick = $urandom_range(99);
		if (pick < 6) begin
			a = $urandom_range(r - 2, 0);
			b = $urandom_range(r - 1, a + 1);
			syms[b] = syms[a];
		end else if (pick < 10) begin
			syms[$urandom_range(r - 1, 0)] = $urandom_range(1) ? PLUS_SYM : MINUS_SYM;
		end else if (pick < 14) begin
			r = $urandom_range(1) ? $urandom_range(1, 0) : $urandom_range(31, 17);
		end
		// symbols past the radix are don't-care, anything goes there
		if ($urandom_range(1)) begin
			for (int k = r; k < 16; k++) syms[k] = sym_t'($urandom);
		end
		for (int k = 0; k < 8; k++) begin
			lo[8*k +: 8] = syms[k];
			hi[8*k +: 8] = syms[k + 8];
		end
		configure(lo, hi, r);
	endtask

	function automatic logic [WIDTH_DEF-1:0] rand_number();
		longint p;
		int     r;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return $urandom;
			5: return $urandom_range(40) - 20;
			6: begin
				case ($urandom_range(4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0;
					3: return 32'hffff_ffff;
					default: return 32'h1;
				endcase
			end
			7: begin
				p = $urandom >> $urandom_range(31);
				return $urandom_range(1) ? -p[31:0] : p[31:0];
			end
			default: begin
				// powers of the radix and their neighbors hit digit-count boundaries
				r = (cur_radix < 2 || cur_radix > 16) ? 10 : cur_radix;
				p = 1;
				repeat ($urandom_range(31)) if (p * r <= 64'sh7fff_ffff) p = p * r;
				case ($urandom_range(3))
					0: return p[31:0];
					1: return p[31:0] - 1;
					2: return -p[31:0];
					default: return -(p[31:0] - 1);
				endcase
			end
		endcase
	endfunction

	initial begin
		int chunk;
		int sent_in_phase;
		bit paused;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		num_bus.valid = 1'b0;
		num_bus.number = '0;
		text_bus.ready = 1'b0;
		src_idle = 19;
		recv_idle = 85;
		cur_radix = 0;
		numbers_sent = 0;
		reg_writes = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// radix still zero out of reset: no text
		send_number(32'd5);
		send_number(-32'sd3);

		// decimal, with sign characters parked in the unused symbols
		configure("76543210", "-+ZZ-+98", 10);
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'hffff_ffff);
		send_number(32'h7fff_ffff);
		send_number(32'h8000_0000);
		send_number(-32'sd10);

		// binary: most negative value gives the longest text
		configure({48'h0, "10"}, 64'h0, 2);
		send_number(32'h8000_0000);
		send_number(32'h7fff_ffff);
		send_number(32'd0);

		// full sixteen symbols, including a zero byte and 0xff
		configure(64'h0706_0504_0302_ff00, 64'hf0e0_d0c0_b0a0_9080, 16);
		send_number(32'hffff_ffff);
		send_number(32'h89ab_cdef);

		// radix out of range
		configure("76543210", "FEDCBA98", 1);
		send_number(32'd7);
		configure("76543210", "FEDCBA98", 31);
		send_number(32'd7);
		configure("76543210", "FEDCBA98", 17);
		send_number(32'd7);

		// sign characters in use
		configure("76543210", "+EDCBA98", 16);
		send_number(32'd255);
		configure("7654321-", "FEDCBA98", 16);
		send_number(32'd255);

		// repeated symbols: widest pair and a pair in the middle
		configure("76543210", "0EDCBA98", 16);
		send_number(32'd1234);
		configure("76543210", "ZZZZZZ38", 10);
		send_number(32'd1234);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin src_idle = 19; recv_idle = 85; end
				1: begin src_idle = 85; recv_idle = 19; end
				default: begin src_idle = 0; recv_idle = 0; end
			endcase
			sent_in_phase = 0;
			paused = 1'b0;
			while (sent_in_phase < PHASE_ITEMS) begin
				random_alphabet();
				chunk = $urandom_range(20, 8);
				for (int i = 0; i < chunk; i++) begin
					if (!paused && sent_in_phase >= 60) begin
						// hold the next number until all text is out
						wait_text_done();
						paused = 1'b1;
					end
					send_number(rand_number());
					sent_in_phase++;
				end
			end
		end

		wait_text_done();
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("covered %0d numbers (%0d under an unusable alphabet) and %0d text beats,",
			numbers_sent, silent_numbers, chars_checked);
		$display("with %0d register writes across radix 0 to 31 and three idling mixes",
			reg_writes);
		if (fails == 0 && due_count == 0) begin
			$display("** signed_integer_to_radix_text_top: PASSED **");
		end else begin
			$display("** signed_integer_to_radix_text_top: FAILED **");
		end
		$finish;
	end

endmodule
